// ===== src/nir_pkg.sv =====
// shared types and constants for the value range index search block
package nir_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int VAL_W = 32;
    localparam int IDX_W = 11;
    localparam int POS_W = 10;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    // request tdata layout, lowest field first
    localparam int VAL_LSB  = 0;
    localparam int IDX_LSB  = VAL_LSB + VAL_W;
    localparam int LO_LSB   = IDX_LSB + IDX_W;
    localparam int HI_LSB   = LO_LSB + VAL_W;
    localparam int S_DATA_W = ((HI_LSB + VAL_W + 7) / 8) * 8;
    localparam int S_USER_W = OP_W;

    localparam int M_DATA_W = ((POS_W + 7) / 8) * 8;
    localparam int M_USER_W = ST_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FOUND = 2'd1,
        ST_NONE  = 2'd2,
        ST_FULL  = 2'd3
    } st_t;

    // controls broadcast to the cell chain
    typedef struct packed {
        logic                    shift;
        logic signed [VAL_W-1:0] tail;
    } chain_ctl_t;

endpackage

// ===== src/nir_cell.sv =====
// one storage cell of the rotating value chain
module nir_cell
    import nir_pkg::*;
(
    input  logic                    aclk,
    input  logic                    shift,
    input  logic signed [VAL_W-1:0] d,
    output logic signed [VAL_W-1:0] q
);

    logic signed [VAL_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            value_reg <= d;
        end
    end

    assign q = value_reg;

endmodule

// ===== src/nir_ctrl.sv =====
// sequencer: rotates the chain to the wanted position, appends, scans, holds the result
module nir_ctrl
    import nir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  op_t                     in_op,
    input  logic signed [VAL_W-1:0] in_value,
    input  logic [IDX_W-1:0]        in_start,
    input  logic signed [VAL_W-1:0] in_low,
    input  logic signed [VAL_W-1:0] in_high,
    input  logic signed [VAL_W-1:0] head_value,
    output chain_ctl_t              chain_ctl,
    output logic                    out_valid,
    input  logic                    out_ready,
    output st_t                     out_status,
    output logic [POS_W-1:0]        out_pos
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic                    scan_reg, scan_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    out_valid_reg;
    st_t                     out_status_reg;
    logic [POS_W-1:0]        out_pos_reg;

    op_t                     op_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0]        start_reg;
    logic signed [VAL_W-1:0] lo_reg;
    logic signed [VAL_W-1:0] hi_reg;

    logic [WW-1:0]           head_w, start_w, count_w;
    logic [CW-1:0]           head_inc;
    logic [AW-1:0]           head_wrap;
    logic                    full, at_tail, bad_query, at_start, hit, last_pos, out_free;
    logic                    res_ready;
    st_t                     res_status;
    logic [POS_W-1:0]        res_pos;
    logic                    accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign head_w    = WW'(head_reg);
    assign start_w   = WW'(start_reg);
    assign count_w   = WW'(count_reg);
    assign head_inc  = CW'(head_reg) + CW'(1);
    assign head_wrap = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    assign full      = (count_reg == CW'(DEPTH));
    assign at_tail   = (head_w == count_w);
    assign bad_query = (lo_reg > hi_reg) || (start_w >= count_w);
    assign at_start  = (head_w == start_w);
    assign hit       = (head_value >= lo_reg) && (head_value <= hi_reg);
    assign last_pos  = (head_inc == count_reg);

    always_comb begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        chain_ctl.shift = 1'b0;
        chain_ctl.tail  = head_value;
        res_ready       = 1'b0;
        res_status      = ST_DONE;
        res_pos         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_RUN;
                    scan_next  = 1'b0;
                end
            end
            S_RUN: begin
                unique case (op_reg)
                    OP_LOAD: begin
                        if (full) begin
                            res_ready  = 1'b1;
                            res_status = ST_FULL;
                        end else if (at_tail) begin
                            res_ready = 1'b1;
                            // head cell moves to the far end, replaced by the new value
                            if (out_free) begin
                                chain_ctl.shift = 1'b1;
                                chain_ctl.tail  = val_reg;
                                head_next       = head_wrap;
                                count_next      = count_reg + CW'(1);
                            end
                        end else begin
                            chain_ctl.shift = 1'b1;
                            head_next       = head_wrap;
                        end
                    end
                    OP_QUERY: begin
                        if (bad_query) begin
                            res_ready  = 1'b1;
                            res_status = ST_NONE;
                        end else if (scan_reg || at_start) begin
                            if (hit) begin
                                res_ready  = 1'b1;
                                res_status = ST_FOUND;
                                res_pos    = head_w[POS_W-1:0];
                            end else if (last_pos) begin
                                res_ready  = 1'b1;
                                res_status = ST_NONE;
                            end else begin
                                chain_ctl.shift = 1'b1;
                                head_next       = head_wrap;
                                scan_next       = 1'b1;
                            end
                        end else begin
                            chain_ctl.shift = 1'b1;
                            head_next       = head_wrap;
                        end
                    end
                    OP_CLEAR: begin
                        res_ready = 1'b1;
                        if (out_free) begin
                            count_next = '0;
                        end
                    end
                    default: begin
                        res_ready = 1'b1;
                    end
                endcase
                if (res_ready && out_free) begin
                    state_next = S_IDLE;
                    scan_next  = 1'b0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            scan_reg      <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (res_ready && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= in_op;
            val_reg   <= in_value;
            start_reg <= in_start;
            lo_reg    <= in_low;
            hi_reg    <= in_high;
        end
        if (res_ready && out_free) begin
            out_status_reg <= res_status;
            out_pos_reg    <= res_pos;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_pos    = out_pos_reg;

endmodule

// ===== src/next_index_in_value_range.sv =====
// One request at a time: accepted while idle, worked on in the run state, result registered.
// Append: the value is written when the chain head sits at the fill position, after the chain
// is rotated there; a full store returns a full status. Clear: empties the store. Query: rotates
// the cell chain to the start position, then scans one position a cycle at the head cell.
// Reset (aresetn low, synchronous) empties the store; stored values are not cleared.
module next_index_in_value_range
    import nir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // value, start_index, range_low, range_high
    input  logic [S_USER_W-1:0] s_tuser,   // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // position
    output logic [M_USER_W-1:0] m_tuser    // status
);

    chain_ctl_t                         chain_ctl;
    logic signed [DEPTH-1:0][VAL_W-1:0] chain_q;
    st_t                                out_status;
    logic [POS_W-1:0]                   out_pos;

    nir_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (op_t'(s_tuser)),
        .in_value   (s_tdata[VAL_LSB +: VAL_W]),
        .in_start   (s_tdata[IDX_LSB +: IDX_W]),
        .in_low     (s_tdata[LO_LSB +: VAL_W]),
        .in_high    (s_tdata[HI_LSB +: VAL_W]),
        .head_value (chain_q[0]),
        .chain_ctl  (chain_ctl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_pos    (out_pos)
    );

    // cell i holds position head+i; a shift moves every value one cell toward the head
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_last
            nir_cell u_cell (
                .aclk  (aclk),
                .shift (chain_ctl.shift),
                .d     (chain_ctl.tail),
                .q     (chain_q[i])
            );
        end else begin : g_mid
            nir_cell u_cell (
                .aclk  (aclk),
                .shift (chain_ctl.shift),
                .d     (chain_q[i+1]),
                .q     (chain_q[i])
            );
        end
    end

    assign m_tdata = M_DATA_W'(out_pos);
    assign m_tuser = out_status;

endmodule

// ===== src/nir_chk.sv =====
// port-level checks for the value range index search block
module nir_chk
    import nir_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [M_USER_W-1:0] m_tuser
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (in_acc && !out_acc) begin
            pending_next = pending_reg + 2'd1;
        end else if (out_acc && !in_acc) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // a result only for a request taken earlier
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 2'd0)
        else $error("result without an outstanding request");

    // one request at a time: intake closes after each accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("request accepted while another is in work");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_FOUND) |-> m_tdata == '0)
        else $error("nonzero position on a result that is not found");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind next_index_in_value_range nir_chk u_nir_chk (.*);

// ===== tb/next_index_in_value_range_test.sv =====
// testbench for the value range index search block: streamed requests checked against a predictor
`timescale 1ns / 1ps

module next_index_in_value_range_test;
    import nir_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int RAND_ITEMS = 540;
    localparam int STORE_CAP  = 100;
    localparam int HOLD_AT_A  = 12;
    localparam int HOLD_AT_B  = 400;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL       = 2 * DEPTH + 64;
    localparam longint LIMIT  = 20_000_000;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        start;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
    } search_req_t;

    typedef struct packed {
        st_t              status;
        logic [POS_W-1:0] pos;
    } search_ans_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // value, start_index, range_low, range_high
    logic [S_USER_W-1:0] s_tuser  = '0;   // operation
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // position
    logic [M_USER_W-1:0] m_tuser;         // status

    next_index_in_value_range #(
        .DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    search_req_t pending_reqs[$];
    search_ans_t expected_answers[$];

    // predictor state
    logic signed [VAL_W-1:0] stored_vals [DEPTH];
    int                      fill_count = 0;

    // stimulus shaping shadow of the store
    logic signed [VAL_W-1:0] gen_vals [DEPTH];
    int                      gen_count = 0;

    search_req_t in_flight;
    search_ans_t want;
    logic [S_DATA_W-1:0] req_word;
    int     reqs_sent  = 0;
    int     send_wait  = 0;
    int     recv_wait  = 0;
    int     next_wait;
    int     hold_cnt   = 0;
    bit     send_burst = 1'b0;
    bit     recv_burst = 1'b0;
    int     error_cnt  = 0;
    int     results_cnt = 0;
    int     n_done = 0, n_found = 0, n_none = 0, n_full = 0;
    longint cycle_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic search_ans_t find_next_in_range(search_req_t r);
        search_ans_t res;
        res.status = ST_DONE;
        res.pos    = '0;
        case (r.op)
            OP_LOAD: begin
                if (fill_count < DEPTH) begin
                    stored_vals[fill_count] = r.value;
                    fill_count++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            OP_CLEAR: fill_count = 0;
            OP_QUERY: begin
                res.status = ST_NONE;
                if ($signed(r.lo) <= $signed(r.hi)) begin
                    for (int i = int'(r.start); i < fill_count; i++) begin
                        if ($signed(stored_vals[i]) >= $signed(r.lo) &&
                            $signed(stored_vals[i]) <= $signed(r.hi)) begin
                            res.status = ST_FOUND;
                            res.pos    = i[POS_W-1:0];
                            break;
                        end
                    end
                end
            end
            default: ;  // spare code leaves the store alone
        endcase
        return res;
    endfunction

    function automatic int draw_gap(bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_val(longint x);
        if (x < longint'(VAL_MIN))
            return VAL_MIN;
        if (x > longint'(VAL_MAX))
            return VAL_MAX;
        return x[VAL_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:          return VAL_MIN;
            1:          return VAL_MAX;
            2, 3, 4, 5: return $urandom;
            default:    return int'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    task automatic push_req(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value,
                            logic [IDX_W-1:0] start, logic signed [VAL_W-1:0] lo,
                            logic signed [VAL_W-1:0] hi);
        search_req_t r;
        r.op    = op;
        r.value = value;
        r.start = start;
        r.lo    = lo;
        r.hi    = hi;
        pending_reqs.insert(pending_reqs.size(), r);
        if (op == OP_LOAD && gen_count < DEPTH) begin
            gen_vals[gen_count] = value;
            gen_count++;
        end else if (op == OP_CLEAR) begin
            gen_count = 0;
        end
    endtask

    // ignored fields carry random noise
    task automatic push_load(logic signed [VAL_W-1:0] value);
        push_req(OP_LOAD, value, IDX_W'($urandom_range(0, 1024)), $urandom, $urandom);
    endtask

    task automatic push_query(int start, logic signed [VAL_W-1:0] lo,
                              logic signed [VAL_W-1:0] hi);
        push_req(OP_QUERY, $urandom, start[IDX_W-1:0], lo, hi);
    endtask

    task automatic push_other(logic [OP_W-1:0] op);
        push_req(op, $urandom, IDX_W'($urandom_range(0, 1024)), $urandom, $urandom);
    endtask

    task automatic push_random_query();
        int start;
        int target;
        int pick;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        pick = $urandom_range(0, 99);
        if (pick < 65 && gen_count > 0)
            start = $urandom_range(0, gen_count - 1);
        else if (pick < 75)
            start = gen_count;
        else if (pick < 85)
            start = 1024;
        else
            start = $urandom_range(0, 1024);
        pick = $urandom_range(0, 99);
        if (pick < 60 && start < gen_count) begin
            // window around an entry at or after the start, so the scan has a hit
            target = $urandom_range(start, gen_count - 1);
            lo = clamp_val(longint'(gen_vals[target]) - $urandom_range(0, 5));
            hi = clamp_val(longint'(gen_vals[target]) + $urandom_range(0, 5));
        end else if (pick < 75) begin
            lo = $urandom;
            hi = $urandom;
        end else if (pick < 85) begin
            lo = VAL_MIN;
            hi = VAL_MAX;
        end else begin
            lo = int'($urandom_range(0, 50)) - 25;
            hi = int'($urandom_range(0, 50)) - 25;
        end
        push_query(start, lo, hi);
    endtask

    task automatic build_stimulus();
        int n;
        int pick;
        // empty store and spare code
        push_query(0, VAL_MIN, VAL_MAX);
        push_other(OP_SPARE);
        push_load(VAL_MIN);
        push_load(VAL_MAX);
        push_load(-1);
        push_load(0);
        push_load(1);
        push_query(0, VAL_MIN, VAL_MIN);
        push_query(0, VAL_MAX, VAL_MAX);
        push_query(0, -1, -1);
        push_query(3, VAL_MIN, VAL_MAX);
        push_query(0, 0, 1);
        push_query(0, 1, 0);              // empty range
        push_query(0, VAL_MAX, VAL_MIN);  // empty range, extremes
        push_query(5, VAL_MIN, VAL_MAX);  // start at the count
        push_query(1024, VAL_MIN, VAL_MAX);
        push_query(4, -1, 0);
        push_other(OP_SPARE);
        push_query(4, VAL_MIN, VAL_MAX);
        push_other(OP_CLEAR);
        push_query(0, VAL_MIN, VAL_MAX);

        n = 0;
        while (n < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (gen_count >= STORE_CAP || (pick < 4 && gen_count > 0)) begin
                push_other(OP_CLEAR);
                n++;
            end else if (pick < 7) begin
                push_other(OP_SPARE);
            end else if (pick < 50 || gen_count == 0 && pick < 70) begin
                push_load(pick_value());
                n++;
            end else begin
                push_random_query();
                n++;
            end
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            send_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_answers.insert(expected_answers.size(),
                                        find_next_in_range(in_flight));
                reqs_sent <= reqs_sent + 1;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    s_tvalid  <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    in_flight = pending_reqs.pop_front();
                    req_word = '0;
                    req_word[VAL_LSB +: VAL_W] = in_flight.value;
                    req_word[IDX_LSB +: IDX_W] = in_flight.start;
                    req_word[LO_LSB +: VAL_W]  = in_flight.lo;
                    req_word[HI_LSB +: VAL_W]  = in_flight.hi;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= req_word;
                    s_tuser   <= in_flight.op;
                    send_wait <= draw_gap(send_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up into the request side
    always @(posedge aclk) begin
        if (!aresetn)
            hold_cnt <= 0;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (s_tvalid && s_tready && (reqs_sent == HOLD_AT_A || reqs_sent == HOLD_AT_B))
            hold_cnt <= HOLD_LEN;
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else begin
            next_wait = recv_wait;
            if (m_tvalid && m_tready) begin
                results_cnt++;
                if (expected_answers.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= 10)
                        $display("unexpected result %0d: status %0d position %0d",
                                 results_cnt, m_tuser, m_tdata[POS_W-1:0]);
                end else begin
                    want = expected_answers.pop_front();
                    case (want.status)
                        ST_DONE:  n_done++;
                        ST_FOUND: n_found++;
                        ST_NONE:  n_none++;
                        default:  n_full++;
                    endcase
                    if (m_tuser !== want.status || m_tdata[POS_W-1:0] !== want.pos) begin
                        error_cnt++;
                        if (error_cnt <= 10)
                            $display({"result %0d mismatch: expected status %0d ",
                                      "position %0d, got status %0d position %0d"},
                                     results_cnt, want.status, want.pos,
                                     m_tuser, m_tdata[POS_W-1:0]);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                next_wait = draw_gap(recv_burst);
            end
            if (hold_cnt != 0) begin
                m_tready  <= 1'b0;
                recv_wait <= next_wait;
            end else if (next_wait != 0) begin
                m_tready  <= 1'b0;
                recv_wait <= next_wait - 1;
            end else begin
                m_tready  <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("timeout after %0d cycles, %0d requests still expected",
                     cycle_cnt, expected_answers.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
        if (expected_answers.size() != 0)
            error_cnt++;
        $display("covered %0d requests: %0d hits, %0d misses, %0d appends dropped on a full store",
                 results_cnt, n_found, n_none, n_full);
        $display("plus %0d appends, clears and spare codes, with random stalls on both sides",
                 n_done);
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", error_cnt);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/nir_pkg.sv
src/nir_cell.sv
src/nir_ctrl.sv
src/next_index_in_value_range.sv
src/nir_chk.sv
tb/next_index_in_value_range_test.sv
